### hdl/vrp_pkg.sv
// vrp_pkg: constants, register indexes, pipeline types and the saturation
// helper of the vertex rotate and project block. No dependencies.
package vrp_pkg;

   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 512;

   localparam int CRD_W  = 16;             // vertex, trig, position, pixel scale
   localparam int PAIR_W = 2 * CRD_W;      // product of two trig values
   localparam int SUM_W  = 48;             // world coordinate at 2^-36
   localparam int FRAC_DROP = 12;          // 2^-36 down to 2^-24
   localparam int WLD_W  = SUM_W - FRAC_DROP;
   localparam int NUM_W  = 55;             // projection numerator
   localparam int MAG_W  = NUM_W - 1;
   localparam int D_W    = WLD_W - 1 + 5;  // world z times 32, z positive
   localparam int Q_W    = 16;             // quotient bits before saturation
   localparam int CMP_W  = D_W + Q_W + 1;
   localparam int IDX_W  = 3;

   typedef enum logic [IDX_W-1:0] {
      REG_COS_YAW     = 3'd0,
      REG_SIN_YAW     = 3'd1,
      REG_COS_PITCH   = 3'd2,
      REG_SIN_PITCH   = 3'd3,
      REG_POS_X       = 3'd4,
      REG_POS_Y       = 3'd5,
      REG_POS_Z       = 3'd6,
      REG_PIXEL_SCALE = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [Q_W-1:0]   quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type         x;
      lane_type         y;
      logic [D_W-1:0]   d;
      logic             behind;
   } div_type;

   typedef struct packed {
      logic [CRD_W-1:0] val;
      logic             clip;
   } sat_type;

   // truncated quotient with sign applied, saturated to 16 bits
   function automatic sat_type sat_lane(input lane_type l);
      sat_type r;
      r.clip = 1'b0;
      r.val  = l.quo;
      if (l.neg) begin
         if (l.ovf || l.quo > 16'd32768) begin
            r.val  = 16'h8000;
            r.clip = 1'b1;
         end else begin
            r.val = CRD_W'(-l.quo);
         end
      end else if (l.ovf || l.quo > 16'd32767) begin
         r.val  = 16'h7FFF;
         r.clip = 1'b1;
      end
      return r;
   endfunction

endpackage

### hdl/vertex_rotate_project.sv
// vertex_rotate_project: yaw/pitch rotation, translation and perspective
// projection of one vertex per cycle through a fixed pipeline.
// Depends on vrp_pkg.
//
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, req_vertex_x/y/z  | in (stall out)
//  rsp     | rsp_valid, rsp_stall, rsp_screen_x/y,   | out (stall in)
//          | rsp_behind_camera, rsp_clipped          |
//  csr     | csr_wr_en, csr_index, csr_wdata         | in
//
// one item per cycle while rsp_stall does not hold the pipe; rsp_valid is registered
// stages: input, rotation products, world sum, projection products, magnitude,
// range check, then one restoring divide step per quotient bit, then saturation
// the whole pipe advances together; it holds only while a result waits on rsp_stall
// synchronous reset clears the valid bits and loads the register defaults
module vertex_rotate_project
   import vrp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [CRD_W-1:0] req_vertex_x,
   input  logic signed [CRD_W-1:0] req_vertex_y,
   input  logic signed [CRD_W-1:0] req_vertex_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [CRD_W-1:0] rsp_screen_x,
   output logic signed [CRD_W-1:0] rsp_screen_y,
   output logic                    rsp_behind_camera,
   output logic                    rsp_clipped,
   input  logic                    csr_wr_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CRD_W-1:0]        csr_wdata
);

   logic signed [CRD_W-1:0] cy_ff, sy_ff, cp_ff, sp_ff, posx_ff, posy_ff, posz_ff;
   logic [CRD_W-1:0]        ps_ff;
   logic signed [PAIR_W-1:0] sysp_ff, sycp_ff, cysp_ff, cycp_ff;

   logic en;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [Q_W:0] dv_ff;
   logic rsp_valid_ff;

   logic signed [CRD_W-1:0] vx_ff, vy_ff, vz_ff;
   logic signed [PAIR_W-1:0] px1_ff, py1_ff, py2_ff, pz1_ff;
   logic signed [CRD_W+PAIR_W-1:0] px2_ff, px3_ff, pz2_ff, pz3_ff;
   logic signed [SUM_W-1:0] sx_in, sy_in, sz_in;
   logic signed [WLD_W-1:0] wx_ff, wy_ff, wz_ff;
   logic signed [CRD_W:0] ps_s;
   logic signed [NUM_W-1:0] mx, my, cx, cyc, nx_in, ny_in, nx_ff, ny_ff;
   logic [D_W-1:0] d4_ff, d5_ff;
   logic s3_beh_ff, s4_beh_ff, s5_beh_ff;
   logic [MAG_W-1:0] mx_ff, my_ff;
   logic negx_ff, negy_ff;
   logic [NUM_W-1:0] absx, absy;
   div_type div_ff [0:Q_W];
   div_type div_in [1:Q_W];
   sat_type satx, saty;
   logic signed [CRD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic rsp_beh_ff, rsp_clip_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cy_ff   <= 16'sd16384;
         sy_ff   <= '0;
         cp_ff   <= 16'sd16384;
         sp_ff   <= '0;
         posx_ff <= '0;
         posy_ff <= '0;
         posz_ff <= 16'sd1280;
         ps_ff   <= 16'd5338;
      end else if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_COS_YAW:     cy_ff   <= csr_wdata;
            REG_SIN_YAW:     sy_ff   <= csr_wdata;
            REG_COS_PITCH:   cp_ff   <= csr_wdata;
            REG_SIN_PITCH:   sp_ff   <= csr_wdata;
            REG_POS_X:       posx_ff <= csr_wdata;
            REG_POS_Y:       posy_ff <= csr_wdata;
            REG_POS_Z:       posz_ff <= csr_wdata;
            REG_PIXEL_SCALE: ps_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // basis pair products are registered and follow the registers in the next cycle
   always_ff @(posedge clock) begin
      sysp_ff <= sy_ff * sp_ff;
      sycp_ff <= sy_ff * cp_ff;
      cysp_ff <= cy_ff * sp_ff;
      cycp_ff <= cy_ff * cp_ff;
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         dv_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         dv_ff   <= {dv_ff[Q_W-1:0], s5_v_ff};
         rsp_valid_ff <= dv_ff[Q_W];
      end
   end

   // world sums at 2^-36, floored to 2^-24 by dropping the low bits
   always_comb begin
      sx_in = (SUM_W'(px1_ff) <<< 14) + SUM_W'(px2_ff) - SUM_W'(px3_ff)
            + (SUM_W'(posx_ff) <<< 28);
      sy_in = (SUM_W'(py1_ff) <<< 14) + (SUM_W'(py2_ff) <<< 14)
            + (SUM_W'(posy_ff) <<< 28);
      sz_in = (SUM_W'(pz1_ff) <<< 14) - SUM_W'(pz2_ff) + SUM_W'(pz3_ff)
            + (SUM_W'(posz_ff) <<< 28);
   end

   assign ps_s = $signed({1'b0, ps_ff});
   assign mx   = wx_ff * ps_s;
   assign my   = wy_ff * ps_s;
   assign cx   = wz_ff * SCREEN_WIDTH;
   assign cyc  = wz_ff * SCREEN_HEIGHT;
   assign nx_in = (mx <<< 1) + (cx <<< 4);
   assign ny_in = (my <<< 1) + (cyc <<< 4);

   assign absx = nx_ff[NUM_W-1] ? NUM_W'(-nx_ff) : NUM_W'(nx_ff);
   assign absy = ny_ff[NUM_W-1] ? NUM_W'(-ny_ff) : NUM_W'(ny_ff);

   // one restoring step per stage, quotient bit Q_W-1 first
   always_comb begin
      logic [CMP_W-1:0] ds;
      for (int k = 1; k <= Q_W; k++) begin
         div_in[k] = div_ff[k-1];
         ds = CMP_W'(div_ff[k-1].d) << (Q_W - k);
         if (CMP_W'(div_ff[k-1].x.rem) >= ds) begin
            div_in[k].x.rem = div_ff[k-1].x.rem - ds[MAG_W-1:0];
            div_in[k].x.quo[Q_W-k] = 1'b1;
         end
         if (CMP_W'(div_ff[k-1].y.rem) >= ds) begin
            div_in[k].y.rem = div_ff[k-1].y.rem - ds[MAG_W-1:0];
            div_in[k].y.quo[Q_W-k] = 1'b1;
         end
      end
   end

   assign satx = sat_lane(div_ff[Q_W].x);
   assign saty = sat_lane(div_ff[Q_W].y);

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff <= req_vertex_x;
         vy_ff <= req_vertex_y;
         vz_ff <= req_vertex_z;

         px1_ff <= vx_ff * cy_ff;
         px2_ff <= vy_ff * sysp_ff;
         px3_ff <= vz_ff * sycp_ff;
         py1_ff <= vy_ff * cp_ff;
         py2_ff <= vz_ff * sp_ff;
         pz1_ff <= vx_ff * sy_ff;
         pz2_ff <= vy_ff * cysp_ff;
         pz3_ff <= vz_ff * cycp_ff;

         wx_ff <= sx_in[SUM_W-1:FRAC_DROP];
         wy_ff <= sy_in[SUM_W-1:FRAC_DROP];
         wz_ff <= sz_in[SUM_W-1:FRAC_DROP];
         s3_beh_ff <= ($signed(sz_in[SUM_W-1:FRAC_DROP]) <= 0);

         nx_ff <= nx_in;
         ny_ff <= ny_in;
         d4_ff <= {wz_ff[WLD_W-2:0], 5'b0};
         s4_beh_ff <= s3_beh_ff;

         mx_ff   <= absx[MAG_W-1:0];
         my_ff   <= absy[MAG_W-1:0];
         negx_ff <= nx_ff[NUM_W-1];
         negy_ff <= ny_ff[NUM_W-1];
         d5_ff   <= d4_ff;
         s5_beh_ff <= s4_beh_ff;

         // quotient of 2^16 or more saturates either way
         div_ff[0].x.rem <= mx_ff;
         div_ff[0].x.quo <= '0;
         div_ff[0].x.neg <= negx_ff;
         div_ff[0].x.ovf <= CMP_W'(mx_ff) >= (CMP_W'(d5_ff) << Q_W);
         div_ff[0].y.rem <= my_ff;
         div_ff[0].y.quo <= '0;
         div_ff[0].y.neg <= negy_ff;
         div_ff[0].y.ovf <= CMP_W'(my_ff) >= (CMP_W'(d5_ff) << Q_W);
         div_ff[0].d      <= d5_ff;
         div_ff[0].behind <= s5_beh_ff;
         for (int k = 1; k <= Q_W; k++) begin
            div_ff[k] <= div_in[k];
         end

         rsp_beh_ff <= div_ff[Q_W].behind;
         if (div_ff[Q_W].behind) begin
            rsp_x_ff    <= '0;
            rsp_y_ff    <= '0;
            rsp_clip_ff <= 1'b0;
         end else begin
            rsp_x_ff    <= satx.val;
            rsp_y_ff    <= saty.val;
            rsp_clip_ff <= satx.clip || saty.clip;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_screen_x      = rsp_x_ff;
   assign rsp_screen_y      = rsp_y_ff;
   assign rsp_behind_camera = rsp_beh_ff;
   assign rsp_clipped       = rsp_clip_ff;

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_camera |->
         rsp_screen_x == 0 && rsp_screen_y == 0 && !rsp_clipped)
      else $error("behind-camera item with non-zero coordinates");

   a_clip_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_screen_x == 16'sh7FFF || rsp_screen_x == -16'sh8000 ||
         rsp_screen_y == 16'sh7FFF || rsp_screen_y == -16'sh8000)
      else $error("clipped item without a saturated coordinate");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      dv_ff[Q_W] && !div_ff[Q_W].behind && !div_ff[Q_W].x.ovf |->
         CMP_W'(div_ff[Q_W].x.rem) < CMP_W'(div_ff[Q_W].d))
      else $error("divide remainder not below divisor");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
